// ----- hdl/vlwe_pkg.sv -----
`timescale 1ns / 1ps

package vlwe_pkg;

	localparam logic [2:0] SETTLE_FRAMES = 3'd6;
	localparam logic [1:0] ONSET_FRAMES  = 2'd2;

	localparam logic [9:0]  QUIET_MAX   = 10'h3FF;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	localparam logic [9:0]  CUTOFF_RESET = 10'd60;
	localparam logic [15:0] CAP_RESET    = 16'd750;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_LISTEN_START = 3'd1,
		EV_END_SILENCE  = 3'd2,
		EV_END_CAP      = 3'd3,
		EV_WIN_EXPIRED  = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		REG_WAKE_ENABLE = 2'd0,
		REG_SILENCE_CUT = 2'd1,
		REG_LISTEN_CAP  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic        wake_enable;
		logic [9:0]  silence_cutoff_frames;
		logic [15:0] listen_cap_frames;
	} cfg_t;

	typedef struct packed {
		logic        vad_speech;
		logic        wake_hit;
		logic        manual_request;
		logic        arm_window;
		logic [15:0] window_frames;
	} item_t;

	typedef struct packed {
		event_t ev;
		logic   listening;
		logic   floor_locked;
		logic   window_open;
	} result_t;

endpackage

// ----- hdl/vlwe_core.sv -----
`timescale 1ns / 1ps

module vlwe_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  vlwe_pkg::item_t  item,
	input  vlwe_pkg::cfg_t   cfg,
	output vlwe_pkg::result_t res
);

	logic        listen_open_q, speech_seen_q, follow_active_q, floor_hold_q;
	logic [9:0]  quiet_count_q;
	logic [15:0] listen_elapsed_q, follow_left_q;
	logic [2:0]  settle_run_q;
	logic [1:0]  onset_run_q;

	logic        lo, ss, fa, fh, trig, jo, by_s, by_c;
	logic [9:0]  qc, cutoff;
	logic [15:0] le, fl;
	logic [2:0]  sr;
	logic [1:0]  onr;
	vlwe_pkg::event_t ev;

	always_comb begin
		lo  = listen_open_q;
		ss  = speech_seen_q;
		fa  = follow_active_q;
		fh  = floor_hold_q;
		qc  = quiet_count_q;
		le  = listen_elapsed_q;
		fl  = follow_left_q;
		sr  = settle_run_q;
		onr = onset_run_q;
		ev  = vlwe_pkg::EV_NONE;
		jo  = 1'b0;
		by_s = 1'b0;
		by_c = 1'b0;
		cutoff = (cfg.silence_cutoff_frames == 10'd0) ? 10'd1 : cfg.silence_cutoff_frames;

		if (item.arm_window) begin
			sr  = 3'd0;
			onr = 2'd0;
			if (item.window_frames == 16'd0) begin
				fa = 1'b0;
				fl = 16'd0;
			end else begin
				fa = 1'b1;
				fl = item.window_frames;
				fh = 1'b0;
			end
		end

		trig = (cfg.wake_enable & item.wake_hit) | item.manual_request;

		if (!trig && !lo && fa) begin
			if (fl == 16'd0) begin
				fa  = 1'b0;
				sr  = 3'd0;
				onr = 2'd0;
				ev  = vlwe_pkg::EV_WIN_EXPIRED;
			end else if (!item.vad_speech) begin
				if (sr < vlwe_pkg::SETTLE_FRAMES) begin
					sr = sr + 3'd1;
				end
				onr = 2'd0;
			end else if (sr >= vlwe_pkg::SETTLE_FRAMES) begin
				onr = onr + 2'd1;
				if (onr >= vlwe_pkg::ONSET_FRAMES) begin
					fa   = 1'b0;
					fl   = 16'd0;
					sr   = 3'd0;
					onr  = 2'd0;
					trig = 1'b1;
				end
			end
		end

		if (fa && fl != 16'd0) begin
			fl = fl - 16'd1;
		end

		if (trig && !lo) begin
			ev = vlwe_pkg::EV_LISTEN_START;
			lo = 1'b1;
			le = 16'd0;
			qc = 10'd0;
			ss = 1'b0;
			fh = 1'b1;
			jo = 1'b1;
		end

		if (lo) begin
			if (item.vad_speech) begin
				ss = 1'b1;
				qc = 10'd0;
			end else if (ss && qc < vlwe_pkg::QUIET_MAX) begin
				qc = qc + 10'd1;
			end
			by_s = qc >= cutoff;
			if (!jo) begin
				by_c = le >= cfg.listen_cap_frames;
				if (le < vlwe_pkg::ELAPSED_MAX) begin
					le = le + 16'd1;
				end
			end
			if (by_s || by_c) begin
				ev = by_s ? vlwe_pkg::EV_END_SILENCE : vlwe_pkg::EV_END_CAP;
				lo = 1'b0;
				qc = 10'd0;
				fh = 1'b0;
			end
		end

		res.ev           = ev;
		res.listening    = lo;
		res.floor_locked = fh;
		res.window_open  = fa && (fl != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_open_q    <= 1'b0;
			speech_seen_q    <= 1'b0;
			follow_active_q  <= 1'b0;
			floor_hold_q     <= 1'b0;
			quiet_count_q    <= 10'd0;
			listen_elapsed_q <= 16'd0;
			follow_left_q    <= 16'd0;
			settle_run_q     <= 3'd0;
			onset_run_q      <= 2'd0;
		end else if (step_en) begin
			listen_open_q    <= lo;
			speech_seen_q    <= ss;
			follow_active_q  <= fa;
			floor_hold_q     <= fh;
			quiet_count_q    <= qc;
			listen_elapsed_q <= le;
			follow_left_q    <= fl;
			settle_run_q     <= sr;
			onset_run_q      <= onr;
		end
	end

endmodule

// ----- hdl/voice_listen_window_endpointer_unit.sv -----
`timescale 1ns / 1ps

// One input transaction per audio frame yields exactly one result transaction. An accepted
// frame is held in an input register, is evaluated against the endpointer state
// in a single pass, and lands in the result register, so the block sustains one frame per
// cycle while out_ready is high; while a result waits, a new frame can still enter the empty
// input register. Configuration writes take effect on the next evaluated frame.

module voice_listen_window_endpointer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        vad_speech,
	input  logic        wake_hit,
	input  logic        manual_request,
	input  logic        arm_window,
	input  logic [15:0] window_frames,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic        listening,
	output logic        floor_locked,
	output logic        window_open,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	vlwe_pkg::cfg_t    cfg_q;
	vlwe_pkg::item_t   item_s1;
	vlwe_pkg::result_t step_res;
	vlwe_pkg::result_t res_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_enable           <= 1'b1;
			cfg_q.silence_cutoff_frames <= vlwe_pkg::CUTOFF_RESET;
			cfg_q.listen_cap_frames     <= vlwe_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				vlwe_pkg::REG_WAKE_ENABLE: cfg_q.wake_enable <= cfg_data[0];
				vlwe_pkg::REG_SILENCE_CUT: cfg_q.silence_cutoff_frames <= cfg_data[9:0];
				vlwe_pkg::REG_LISTEN_CAP:  cfg_q.listen_cap_frames <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.vad_speech     <= vad_speech;
			item_s1.wake_hit       <= wake_hit;
			item_s1.manual_request <= manual_request;
			item_s1.arm_window     <= arm_window;
			item_s1.window_frames  <= window_frames;
		end
	end

	vlwe_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = res_q.ev;
	assign listening    = res_q.listening;
	assign floor_locked = res_q.floor_locked;
	assign window_open  = res_q.window_open;

endmodule
